// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros used by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPLY(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLY(name, clk, rst_n, pre, post)
`define ASSERT_NEXT(name, clk, rst_n, pre, post)

`endif

`endif

// ===== rtl/ssdm_pkg.sv =====
// ----------------------------------------------------------------------------
// ssdm_pkg
// types, constants and glyph functions for the seven segment display mux
// ----------------------------------------------------------------------------
package ssdm_pkg;

  typedef enum logic [1:0] {
    LAYOUT_SINGLE = 2'd0,
    LAYOUT_PAIR   = 2'd1,
    LAYOUT_QUAD   = 2'd2,
    LAYOUT_ALT    = 2'd3
  } layout_e;

  localparam logic [2:0] POS_UNITS     = 3'd0;
  localparam logic [2:0] POS_TENS      = 3'd1;
  localparam logic [2:0] POS_HUNDREDS  = 3'd2;
  localparam logic [2:0] POS_THOUSANDS = 3'd3;
  localparam logic [2:0] POS_LEDS      = 3'd4;

  localparam logic [1:0] CFG_LAYOUT   = 2'd0;
  localparam logic [1:0] CFG_DISPLAY  = 2'd1;
  localparam logic [1:0] CFG_LED_MODE = 2'd2;

  localparam logic [3:0] GLYPH_SEL_DOT   = 4'd1;
  localparam logic [3:0] GLYPH_SEL_UNDER = 4'd2;
  localparam logic [3:0] GLYPH_SEL_DASH  = 4'd3;
  localparam logic [3:0] GLYPH_SEL_BAR   = 4'd4;

  localparam logic [7:0] GLYPH_DOT   = 8'h01;
  localparam logic [7:0] GLYPH_UNDER = 8'h02;
  localparam logic [7:0] GLYPH_DASH  = 8'h20;
  localparam logic [7:0] GLYPH_BAR   = 8'h10;
  localparam logic [7:0] GLYPH_NONE  = 8'h00;

  localparam logic [15:0] DEC_MAX_SINGLE = 16'd9999;
  localparam logic [7:0]  DEC_MAX_BYTE   = 8'd99;
  localparam logic [7:0]  DEC_MAX_DIGIT  = 8'd9;

  // reciprocal multipliers, exact over the decimal ranges in use
  localparam logic [31:0] RECIP_10    = 32'd52429;  // >> 19
  localparam logic [31:0] RECIP_100   = 32'd5243;   // >> 19
  localparam logic [31:0] RECIP_1000  = 32'd8389;   // >> 23
  localparam logic [15:0] RECIP_10_B  = 16'd205;    // >> 11, byte range

  typedef logic [7:0] digit_t;

  typedef struct packed {
    logic        tick;
    logic [15:0] value_single;
    logic [7:0]  pair_high;
    logic [7:0]  pair_low;
    logic [7:0]  digit_thousands;
    logic [7:0]  digit_hundreds;
    logic [7:0]  digit_tens;
    logic [7:0]  digit_units;
    logic [7:0]  led_number;
    logic [7:0]  led_bits;
  } in_item_t;

  typedef struct packed {
    digit_t thou;
    digit_t hund;
    digit_t tens;
    digit_t units;
  } digits_t;

  typedef struct packed {
    logic    tick;
    logic    keep;
    digits_t digits;
    logic [7:0] led_seg;
  } formed_t;

  function automatic logic [7:0] seg_of(input digit_t d);
    logic [7:0] seg;
    unique case (d[3:0])
      4'h0: seg = 8'hDE;
      4'h1: seg = 8'h88;
      4'h2: seg = 8'hB6;
      4'h3: seg = 8'hBA;
      4'h4: seg = 8'hE8;
      4'h5: seg = 8'h7A;
      4'h6: seg = 8'h7E;
      4'h7: seg = 8'h98;
      4'h8: seg = 8'hFE;
      4'h9: seg = 8'hF8;
      4'hA: seg = 8'hFC;
      4'hB: seg = 8'h6E;
      4'hC: seg = 8'h56;
      4'hD: seg = 8'hAE;
      4'hE: seg = 8'h76;
      4'hF: seg = 8'h74;
      default: seg = 8'h00;
    endcase
    if (d[7:4] != 4'h0) begin
      seg = 8'h00;
    end
    return seg;
  endfunction

  function automatic logic [7:0] blank_glyph(input logic [3:0] sel);
    logic [7:0] g;
    unique case (sel)
      GLYPH_SEL_DOT:   g = GLYPH_DOT;
      GLYPH_SEL_UNDER: g = GLYPH_UNDER;
      GLYPH_SEL_DASH:  g = GLYPH_DASH;
      GLYPH_SEL_BAR:   g = GLYPH_BAR;
      default:         g = GLYPH_NONE;
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/seven_segment_display_mux_core.sv =====
// ----------------------------------------------------------------------------
// seven_segment_display_mux_core
// path: input register, then output register, which holds each result
// throughput: one transaction per cycle; the input register refills in the cycle
//   its transaction moves on, and input stalls only while a result waits
// reset: asynchronous, active low; clears config, tick counter, phase and held digits
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module seven_segment_display_mux_core #(
  parameter int TICKS_PER_PHASE = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        tick_i,
  input  logic [15:0] value_single_i,
  input  logic [7:0]  pair_high_i,
  input  logic [7:0]  pair_low_i,
  input  logic [7:0]  digit_thousands_i,
  input  logic [7:0]  digit_hundreds_i,
  input  logic [7:0]  digit_tens_i,
  input  logic [7:0]  digit_units_i,
  input  logic [7:0]  led_number_i,
  input  logic [7:0]  led_bits_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  segments_o,
  output logic [2:0]  position_o
);

  import ssdm_pkg::*;

  localparam int CntW = $clog2(TICKS_PER_PHASE + 1);

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_UNITS     = 3'd1,
    PH_TENS      = 3'd2,
    PH_HUNDREDS  = 3'd3,
    PH_THOUSANDS = 3'd4,
    PH_LEDS      = 3'd5
  } phase_e;

  // configuration
  layout_e    layout_q;
  logic [7:0] disp_mode_q;
  logic       led_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layout_q    <= LAYOUT_SINGLE;
      disp_mode_q <= 8'h00;
      led_mode_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LAYOUT:   layout_q    <= layout_e'(cfg_data_i[1:0]);
        CFG_DISPLAY:  disp_mode_q <= cfg_data_i;
        CFG_LED_MODE: led_mode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic     s1_valid_q, out_valid_q;
  logic     out_free, s1_ready, s1_fire;
  in_item_t s1_q;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || out_free;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_ready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_q <= '{
        tick:            tick_i,
        value_single:    value_single_i,
        pair_high:       pair_high_i,
        pair_low:        pair_low_i,
        digit_thousands: digit_thousands_i,
        digit_hundreds:  digit_hundreds_i,
        digit_tens:      digit_tens_i,
        digit_units:     digit_units_i,
        led_number:      led_number_i,
        led_bits:        led_bits_i
      };
    end
  end

  // digit forming
  logic        hex;
  logic [31:0] prod10, prod100, prod1000;
  logic [12:0] q10;
  logic [6:0]  q100;
  logic [3:0]  q1000;
  logic [15:0] rem_u;
  logic [12:0] rem_t;
  logic [6:0]  rem_h;
  logic [7:0]  ph_dec, pl_dec;
  logic [15:0] ph_prod, pl_prod;
  logic [3:0]  ph_q, pl_q;
  logic [7:0]  ph_r, pl_r;
  formed_t     formed;

  assign hex = (disp_mode_q[7:4] != 4'h0);

  always_comb begin
    prod10   = 32'(s1_q.value_single) * RECIP_10;
    prod100  = 32'(s1_q.value_single) * RECIP_100;
    prod1000 = 32'(s1_q.value_single) * RECIP_1000;
    q10      = prod10[31:19];
    q100     = prod100[25:19];
    q1000    = prod1000[26:23];
    rem_u    = s1_q.value_single - 16'(q10) * 16'd10;
    rem_t    = q10 - 13'(q100) * 13'd10;
    rem_h    = q100 - 7'(q1000) * 7'd10;

    ph_dec  = (s1_q.pair_high > DEC_MAX_BYTE) ? 8'd0 : s1_q.pair_high;
    pl_dec  = (s1_q.pair_low  > DEC_MAX_BYTE) ? 8'd0 : s1_q.pair_low;
    ph_prod = 16'(ph_dec) * RECIP_10_B;
    pl_prod = 16'(pl_dec) * RECIP_10_B;
    ph_q    = ph_prod[14:11];
    pl_q    = pl_prod[14:11];
    ph_r    = ph_dec - 8'(ph_q) * 8'd10;
    pl_r    = pl_dec - 8'(pl_q) * 8'd10;

    formed.tick    = s1_q.tick;
    formed.keep    = 1'b0;
    formed.led_seg = led_mode_q ? s1_q.led_number : s1_q.led_bits;
    unique case (layout_q)
      LAYOUT_PAIR: begin
        if (hex) begin
          formed.digits = '{thou:  8'(s1_q.pair_high[7:4]), hund: 8'(s1_q.pair_high[3:0]),
                            tens:  8'(s1_q.pair_low[7:4]),  units: 8'(s1_q.pair_low[3:0])};
        end else begin
          formed.digits = '{thou: 8'(ph_q), hund: ph_r, tens: 8'(pl_q), units: pl_r};
        end
      end
      LAYOUT_QUAD: begin
        if (hex) begin
          formed.digits = '{thou: s1_q.digit_thousands, hund: s1_q.digit_hundreds,
                            tens: s1_q.digit_tens, units: s1_q.digit_units};
        end else begin
          formed.digits = '{
            thou:  (s1_q.digit_thousands > DEC_MAX_DIGIT) ? 8'd0 : s1_q.digit_thousands,
            hund:  (s1_q.digit_hundreds  > DEC_MAX_DIGIT) ? 8'd0 : s1_q.digit_hundreds,
            tens:  (s1_q.digit_tens      > DEC_MAX_DIGIT) ? 8'd0 : s1_q.digit_tens,
            units: (s1_q.digit_units     > DEC_MAX_DIGIT) ? 8'd0 : s1_q.digit_units
          };
        end
      end
      default: begin
        if (hex) begin
          formed.digits = '{thou:  8'(s1_q.value_single[15:12]),
                            hund:  8'(s1_q.value_single[11:8]),
                            tens:  8'(s1_q.value_single[7:4]),
                            units: 8'(s1_q.value_single[3:0])};
        end else begin
          formed.keep   = (s1_q.value_single > DEC_MAX_SINGLE);
          formed.digits = '{thou: 8'(q1000), hund: 8'(rem_h[3:0]),
                            tens: 8'(rem_t[3:0]), units: 8'(rem_u[3:0])};
        end
      end
    endcase
  end

  // phase stepping and segment select
  digits_t     held_q, held_d;
  logic [CntW-1:0] cnt_q, cnt_inc;
  phase_e      phase_q, phase_d;
  logic        step, emit, m0, c0, d0;
  logic [7:0]  glyph, seg_d, seg_q;
  logic [2:0]  pos_d, pos_q;

  always_comb begin
    held_d  = formed.keep ? held_q : formed.digits;
    cnt_inc = cnt_q + CntW'(1);
    step    = formed.tick && (cnt_inc == CntW'(TICKS_PER_PHASE));
    m0      = (held_d.thou == 8'd0);
    c0      = (held_d.hund == 8'd0);
    d0      = (held_d.tens == 8'd0);
    glyph   = blank_glyph(disp_mode_q[3:0]);
    emit    = 1'b1;
    seg_d   = 8'h00;
    pos_d   = POS_UNITS;
    unique case (phase_q)
      PH_UNITS: begin
        seg_d   = seg_of(held_d.units);
        pos_d   = POS_UNITS;
        phase_d = PH_TENS;
      end
      PH_TENS: begin
        seg_d   = (d0 && c0 && m0) ? glyph : seg_of(held_d.tens);
        pos_d   = POS_TENS;
        phase_d = PH_HUNDREDS;
      end
      PH_HUNDREDS: begin
        seg_d   = (c0 && m0) ? glyph : seg_of(held_d.hund);
        pos_d   = POS_HUNDREDS;
        phase_d = PH_THOUSANDS;
      end
      PH_THOUSANDS: begin
        seg_d   = m0 ? glyph : seg_of(held_d.thou);
        pos_d   = POS_THOUSANDS;
        phase_d = PH_LEDS;
      end
      PH_LEDS: begin
        seg_d   = formed.led_seg;
        pos_d   = POS_LEDS;
        phase_d = PH_UNITS;
      end
      default: begin
        emit    = 1'b0;
        phase_d = PH_UNITS;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      cnt_q       <= '0;
      phase_q     <= PH_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (s1_fire && formed.tick) begin
        held_q <= held_d;
        cnt_q  <= step ? '0 : cnt_inc;
        if (step) begin
          phase_q <= phase_d;
          if (emit) begin
            out_valid_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && step && emit) begin
      seg_q <= seg_d;
      pos_q <= pos_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign segments_o  = seg_q;
  assign position_o  = pos_q;

  `ASSERT_IMPLY(a_pos_range, clk_i, rst_ni, out_valid_o,
                position_o != 3'd5 && position_o != 3'd6 && position_o != 3'd7)
  `ASSERT_IMPLY(a_cnt_below, clk_i, rst_ni, 1'b1, cnt_q < CntW'(TICKS_PER_PHASE))
  `ASSERT_NEXT(a_emit_valid, clk_i, rst_ni, s1_fire && step && emit, out_valid_o)
  `ASSERT_IMPLY(a_stall_full, clk_i, rst_ni, !in_ready_o,
                s1_valid_q && out_valid_q && !out_ready_i)

endmodule

// ===== test/seven_segment_display_mux_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_display_mux_checker
// Follows the register writes and the accepted tick transactions, forms the
// display digits and steps the digit scan the way the core should, and
// compares every accepted result transaction with the oldest predicted one.
// ----------------------------------------------------------------------------
module seven_segment_display_mux_checker #(
  parameter int TICKS_PER_PHASE = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               item_valid_i,
  input  logic               item_ready_i,
  input  ssdm_pkg::in_item_t item_i,
  input  logic               res_valid_i,
  input  logic               res_ready_i,
  input  logic [7:0]         segments_i,
  input  logic [2:0]         position_i,
  output int                 pending_o,
  output int                 fail_count_o
);
  import ssdm_pkg::*;

  typedef struct packed {
    logic [7:0] segments;
    logic [2:0] position;
  } scan_beat_t;

  scan_beat_t expected_beats[$];
  scan_beat_t want_beat;
  scan_beat_t got_beat;

  layout_e    layout;
  logic [7:0] disp_mode;
  logic       led_mode;
  int         ticks_seen;
  logic       scanning;
  logic [2:0] scan_pos;
  digits_t    held;
  int         mismatches;

  function automatic logic [7:0] digit_pattern(input digit_t d);
    logic [7:0] p;
    case (d)
      8'd0:    p = 8'hDE;
      8'd1:    p = 8'h88;
      8'd2:    p = 8'hB6;
      8'd3:    p = 8'hBA;
      8'd4:    p = 8'hE8;
      8'd5:    p = 8'h7A;
      8'd6:    p = 8'h7E;
      8'd7:    p = 8'h98;
      8'd8:    p = 8'hFE;
      8'd9:    p = 8'hF8;
      8'd10:   p = 8'hFC;
      8'd11:   p = 8'h6E;
      8'd12:   p = 8'h56;
      8'd13:   p = 8'hAE;
      8'd14:   p = 8'h76;
      8'd15:   p = 8'h74;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] zero_glyph();
    logic [7:0] g;
    case (disp_mode[3:0])
      GLYPH_SEL_DOT:   g = GLYPH_DOT;
      GLYPH_SEL_UNDER: g = GLYPH_UNDER;
      GLYPH_SEL_DASH:  g = GLYPH_DASH;
      GLYPH_SEL_BAR:   g = GLYPH_BAR;
      default:         g = GLYPH_NONE;
    endcase
    return g;
  endfunction

  function automatic digit_t single_digit(input logic [7:0] d, input logic hex);
    return (hex || d <= DEC_MAX_DIGIT) ? d : 8'd0;
  endfunction

  task automatic capture_digits(input in_item_t it);
    logic        hex;
    logic [7:0]  hi_b;
    logic [7:0]  lo_b;
    logic [15:0] v;
    hex = disp_mode[7:4] != 4'h0;
    v = it.value_single;
    case (layout)
      LAYOUT_PAIR: begin
        if (hex) begin
          held.thou  = {4'h0, it.pair_high[7:4]};
          held.hund  = {4'h0, it.pair_high[3:0]};
          held.tens  = {4'h0, it.pair_low[7:4]};
          held.units = {4'h0, it.pair_low[3:0]};
        end else begin
          hi_b = (it.pair_high > DEC_MAX_BYTE) ? 8'd0 : it.pair_high;
          lo_b = (it.pair_low > DEC_MAX_BYTE) ? 8'd0 : it.pair_low;
          held.thou  = 8'(hi_b / 10);
          held.hund  = 8'(hi_b % 10);
          held.tens  = 8'(lo_b / 10);
          held.units = 8'(lo_b % 10);
        end
      end
      LAYOUT_QUAD: begin
        held.thou  = single_digit(it.digit_thousands, hex);
        held.hund  = single_digit(it.digit_hundreds, hex);
        held.tens  = single_digit(it.digit_tens, hex);
        held.units = single_digit(it.digit_units, hex);
      end
      default: begin
        if (hex) begin
          held.thou  = {4'h0, v[15:12]};
          held.hund  = {4'h0, v[11:8]};
          held.tens  = {4'h0, v[7:4]};
          held.units = {4'h0, v[3:0]};
        end else if (v <= DEC_MAX_SINGLE) begin
          held.thou  = 8'(v / 1000);
          held.hund  = 8'((v / 100) % 10);
          held.tens  = 8'((v / 10) % 10);
          held.units = 8'(v % 10);
        end
      end
    endcase
  endtask

  task automatic predict_scan_step(input in_item_t it);
    scan_beat_t beat;
    logic       thou_z;
    logic       hund_z;
    logic       tens_z;
    if (!it.tick) return;
    capture_digits(it);
    ticks_seen++;
    if (ticks_seen != TICKS_PER_PHASE) return;
    ticks_seen = 0;
    // the first scan step after reset only arms the scan
    if (!scanning) begin
      scanning = 1'b1;
      scan_pos = POS_UNITS;
      return;
    end
    thou_z = held.thou == 8'd0;
    hund_z = held.hund == 8'd0;
    tens_z = held.tens == 8'd0;
    beat.position = scan_pos;
    case (scan_pos)
      POS_UNITS: begin
        beat.segments = digit_pattern(held.units);
        scan_pos = POS_TENS;
      end
      POS_TENS: begin
        beat.segments = (tens_z && hund_z && thou_z) ? zero_glyph() : digit_pattern(held.tens);
        scan_pos = POS_HUNDREDS;
      end
      POS_HUNDREDS: begin
        beat.segments = (hund_z && thou_z) ? zero_glyph() : digit_pattern(held.hund);
        scan_pos = POS_THOUSANDS;
      end
      POS_THOUSANDS: begin
        beat.segments = thou_z ? zero_glyph() : digit_pattern(held.thou);
        scan_pos = POS_LEDS;
      end
      default: begin
        beat.segments = led_mode ? it.led_number : it.led_bits;
        scan_pos = POS_UNITS;
      end
    endcase
    expected_beats.push_back(beat);
  endtask

  task automatic flag_mismatch(input string what, input scan_beat_t want,
                               input scan_beat_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t mismatch (%s): expected segments %h position %0d,",
               $time, what, want.segments, want.position,
               " got segments %h position %0d", got.segments, got.position);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_beats.delete();
      layout     = LAYOUT_SINGLE;
      disp_mode  = 8'h00;
      led_mode   = 1'b0;
      ticks_seen = 0;
      scanning   = 1'b0;
      scan_pos   = POS_UNITS;
      held       = '0;
      mismatches = 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        got_beat.segments = segments_i;
        got_beat.position = position_i;
        if (expected_beats.size() == 0) begin
          flag_mismatch("no transaction expected", '0, got_beat);
        end else begin
          want_beat = expected_beats.pop_front();
          if (want_beat.segments !== got_beat.segments) begin
            flag_mismatch("segments", want_beat, got_beat);
          end
          if (want_beat.position !== got_beat.position) begin
            flag_mismatch("position", want_beat, got_beat);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LAYOUT:   layout = layout_e'(cfg_data_i[1:0]);
          CFG_DISPLAY:  disp_mode = cfg_data_i;
          CFG_LED_MODE: led_mode = cfg_data_i[0];
          default: ;
        endcase
      end
      if (item_valid_i && item_ready_i) begin
        predict_scan_step(item_i);
      end
    end
    pending_o    = expected_beats.size();
    fail_count_o = mismatches;
  end

endmodule

// ===== test/seven_segment_display_mux_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_display_mux_core_tb
// Drives tick transactions through the display mux core under a series of
// register settings, first a short directed set of field extremes and then
// random transactions with random idling on both channels. A checker beside
// the core predicts every scan result and counts mismatches.
// ----------------------------------------------------------------------------
module seven_segment_display_mux_core_tb;
  import ssdm_pkg::*;

  localparam int         TICKS_PER_PHASE = 4;
  localparam int         SETTLE_CYCLES   = 6;
  localparam int         STALL_LIMIT     = 4000;
  localparam int         RANDOM_PHASES   = 15;
  localparam int         PHASE_ITEMS     = 60;
  localparam logic [1:0] CFG_SPARE       = 2'd3;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [1:0] cfg_idx_i   = CFG_LAYOUT;
  logic [7:0] cfg_data_i  = 8'h00;
  logic       in_valid_i  = 1'b0;
  in_item_t   cur_item    = '0;
  logic       out_ready_i = 1'b0;
  logic       calm        = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] segments_o;
  logic [2:0] position_o;
  int         pending;
  int         fail_count;
  int         stall_cycles = 0;

  seven_segment_display_mux_core #(
    .TICKS_PER_PHASE(TICKS_PER_PHASE)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .tick_i           (cur_item.tick),
    .value_single_i   (cur_item.value_single),
    .pair_high_i      (cur_item.pair_high),
    .pair_low_i       (cur_item.pair_low),
    .digit_thousands_i(cur_item.digit_thousands),
    .digit_hundreds_i (cur_item.digit_hundreds),
    .digit_tens_i     (cur_item.digit_tens),
    .digit_units_i    (cur_item.digit_units),
    .led_number_i     (cur_item.led_number),
    .led_bits_i       (cur_item.led_bits),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .segments_o       (segments_o),
    .position_o       (position_o)
  );

  seven_segment_display_mux_checker #(
    .TICKS_PER_PHASE(TICKS_PER_PHASE)
  ) scan_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .item_valid_i(in_valid_i),
    .item_ready_i(in_ready_o),
    .item_i      (cur_item),
    .res_valid_i (out_valid_o),
    .res_ready_i (out_ready_i),
    .segments_i  (segments_o),
    .position_i  (position_o),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 16);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL seven_segment_display_mux_core");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // drain every expected result, then let non-result ticks leave the pipeline
  task automatic settle();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic configure(input layout_e lay, input logic [7:0] mode, input logic led);
    logic [7:0] pad;
    settle();
    pad = 8'($urandom_range(255));
    write_reg(CFG_LAYOUT, {pad[7:2], lay});
    write_reg(CFG_DISPLAY, mode);
    write_reg(CFG_LED_MODE, {pad[6:0], led});
  endtask

  task automatic send_tick(input in_item_t it);
    while (!calm && $urandom_range(99) < 16) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    cur_item   = it;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_byte(input int unsigned limit_val);
    logic [7:0] b;
    case ($urandom_range(3))
      0:       b = 8'($urandom_range(limit_val));
      1:       b = 8'($urandom_range(limit_val + 3, limit_val - 2));
      2:       b = 8'($urandom_range(255));
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it.tick = $urandom_range(99) < 88;
    case ($urandom_range(4))
      0:       it.value_single = 16'($urandom_range(99));
      1:       it.value_single = 16'($urandom_range(9999));
      2:       it.value_single = 16'($urandom_range(10003, 9996));
      3:       it.value_single = 16'($urandom_range(999));
      default: it.value_single = 16'($urandom_range(65535));
    endcase
    it.pair_high       = pick_byte(99);
    it.pair_low        = pick_byte(99);
    it.digit_thousands = pick_byte($urandom_range(1) ? 9 : 15);
    it.digit_hundreds  = pick_byte($urandom_range(1) ? 9 : 15);
    it.digit_tens      = pick_byte($urandom_range(1) ? 9 : 15);
    it.digit_units     = pick_byte($urandom_range(1) ? 9 : 15);
    it.led_number      = 8'($urandom_range(255));
    it.led_bits        = 8'($urandom_range(255));
    return it;
  endfunction

  function automatic in_item_t directed_item(input int k);
    in_item_t it;
    it = '0;
    it.tick = 1'b1;
    case (k)
      0: ;
      1: begin
        it.value_single = 16'd9999;
        it.pair_high    = 8'd99;
        it.pair_low     = 8'd99;
        it.digit_thousands = 8'd9;
        it.digit_hundreds  = 8'd9;
        it.digit_tens      = 8'd9;
        it.digit_units     = 8'd9;
        it.led_number      = 8'hFF;
      end
      2: begin
        it.value_single    = 16'd10000;
        it.pair_high       = 8'd100;
        it.pair_low        = 8'd255;
        it.digit_thousands = 8'd10;
        it.digit_hundreds  = 8'd15;
        it.digit_tens      = 8'd16;
        it.digit_units     = 8'd255;
        it.led_number      = 8'h55;
        it.led_bits        = 8'hAA;
      end
      3: it = '1;
      4: begin
        it = rand_item();
        it.tick = 1'b0;
      end
      default: begin
        it.value_single = 16'd5;
        it.pair_low     = 8'd7;
        it.digit_units  = 8'd3;
        it.led_number   = 8'h80;
        it.led_bits     = 8'h01;
      end
    endcase
    return it;
  endfunction

  initial begin : stimulus
    int         p;
    int         n;
    logic [3:0] hi_n;
    logic [3:0] lo_n;
    logic [7:0] mode;
    layout_e    lay;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: field extremes under the single, pair and quad layouts, decimal and, for quad, hex
    configure(LAYOUT_SINGLE, 8'h03, 1'b0);
    write_reg(CFG_SPARE, 8'hFF);
    for (n = 0; n < 6; n++) send_tick(directed_item(n));
    configure(LAYOUT_PAIR, 8'h01, 1'b1);
    for (n = 0; n < 6; n++) send_tick(directed_item(n));
    configure(LAYOUT_QUAD, 8'h04, 1'b0);
    for (n = 0; n < 6; n++) send_tick(directed_item(n));
    configure(LAYOUT_QUAD, 8'hA2, 1'b1);
    for (n = 0; n < 6; n++) send_tick(directed_item(n));

    for (p = 0; p < RANDOM_PHASES; p++) begin
      lay = (p < 4) ? layout_e'(p) : layout_e'($urandom_range(3));
      hi_n = 4'($urandom_range(15, 1));
      lo_n = 4'($urandom_range(15));
      case (p)
        0: mode = 8'h00;
        1: mode = 8'hFF;
        2: mode = 8'h0F;
        3: mode = 8'hF0;
        default: begin
          case ($urandom_range(2))
            0:       mode = {4'h0, 4'($urandom_range(5))};
            1:       mode = {hi_n, lo_n};
            default: mode = 8'($urandom_range(255));
          endcase
        end
      endcase
      configure(lay, mode, (p < 4) ? p[0] : 1'($urandom_range(1)));
      if (p % 4 == 2) write_reg(CFG_SPARE, 8'($urandom_range(255)));
      calm = (p == 5);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 7 && n == PHASE_ITEMS / 2) begin
          in_valid_i = 1'b0;
          while (pending != 0) @(negedge clk_i);
        end
        send_tick(rand_item());
      end
      calm = 1'b0;
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("PASS seven_segment_display_mux_core");
    end else begin
      $display("FAIL seven_segment_display_mux_core");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ssdm_pkg.sv
rtl/seven_segment_display_mux_core.sv
test/seven_segment_display_mux_checker.sv
test/seven_segment_display_mux_core_tb.sv
